[hw/rtl/tmrv_pkg.sv]
// ----------------------------------------------------------------------------
// tmrv_pkg
// Shared types and constants of the triple-redundant voted register file.
// ----------------------------------------------------------------------------
package tmrv_pkg;

  // Number of redundant copies per field
  localparam int unsigned NUM_COPIES = 3;

  // Field widths
  localparam int unsigned MODE_W  = 4;
  localparam int unsigned BATT_W  = 15;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned SEQ_W   = 16;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 32;

  // Reset values and limits (battery in Q8 percent)
  localparam logic [MODE_W-1:0] SAFE_CODE_RESET = 4'd1;
  localparam logic [BATT_W-1:0] BATT_RESET_Q8   = 15'd12800;
  localparam logic [BATT_W-1:0] BATT_FULL_Q8    = 15'd25600;

  // Command codes
  typedef enum logic [3:0] {
    OP_WR_MODE  = 4'd0,
    OP_WR_BATT  = 4'd1,
    OP_WR_TIME  = 4'd2,
    OP_WR_SEQ   = 4'd3,
    OP_RD_MODE  = 4'd4,
    OP_RD_BATT  = 4'd5,
    OP_RD_TIME  = 4'd6,
    OP_RD_SEQ   = 4'd7,
    OP_SCRUB    = 4'd8,
    OP_INJECT   = 4'd9
  } tmrv_op_e;

  // Field codes for fault injection
  typedef enum logic [1:0] {
    FLD_MODE = 2'd0,
    FLD_BATT = 2'd1,
    FLD_TIME = 2'd2,
    FLD_SEQ  = 2'd3
  } tmrv_field_e;

  // Request transaction
  typedef struct packed {
    logic [3:0]        opcode;
    logic [1:0]        field_select;
    logic [1:0]        copy_index;
    logic [DATA_W-1:0] value;
  } tmrv_req_t;

  // Result transaction
  typedef struct packed {
    logic [DATA_W-1:0]  read_value;
    logic               no_majority;
    logic               corrected;
    logic [COUNT_W-1:0] correction_count;
  } tmrv_rsp_t;

  // Agreement status of one set of copies
  typedef struct packed {
    logic all_differ;
    logic all_equal;
  } tmrv_vote_flags_t;

endpackage

[hw/rtl/tmrv_vote.sv]
// ----------------------------------------------------------------------------
// tmrv_vote
// Two-of-three majority voter; with no majority it picks the largest copy
// or a fallback value.
// ----------------------------------------------------------------------------
module tmrv_vote #(
  parameter int unsigned W = 32
) (
  input  logic [W-1:0]                c0_i,
  input  logic [W-1:0]                c1_i,
  input  logic [W-1:0]                c2_i,
  input  logic                        use_max_i,
  input  logic [W-1:0]                fallback_i,
  output logic [W-1:0]                winner_o,
  output tmrv_pkg::tmrv_vote_flags_t  flags_o
);
  import tmrv_pkg::*;

  logic         eq01, eq02, eq12;
  logic [W-1:0] max01, max_all;

  // Compare copies pairwise
  assign eq01 = (c0_i == c1_i);
  assign eq02 = (c0_i == c2_i);
  assign eq12 = (c1_i == c2_i);

  // Find the largest copy
  assign max01   = (c1_i > c0_i) ? c1_i : c0_i;
  assign max_all = (c2_i > max01) ? c2_i : max01;

  // Pick the majority, else largest or fallback
  always_comb begin
    if (eq01 || eq02) begin
      winner_o = c0_i;
    end else if (eq12) begin
      winner_o = c1_i;
    end else if (use_max_i) begin
      winner_o = max_all;
    end else begin
      winner_o = fallback_i;
    end
  end

  assign flags_o.all_differ = !eq01 && !eq02 && !eq12;
  assign flags_o.all_equal  = eq01 && eq12;

endmodule

[hw/rtl/tmrv_batt_vote.sv]
// ----------------------------------------------------------------------------
// tmrv_batt_vote
// Battery voter: floored average of the closest pair of copies, and the
// index of the odd copy that takes the average.
// ----------------------------------------------------------------------------
module tmrv_batt_vote (
  input  logic [tmrv_pkg::BATT_W-1:0] b0_i,
  input  logic [tmrv_pkg::BATT_W-1:0] b1_i,
  input  logic [tmrv_pkg::BATT_W-1:0] b2_i,
  output logic [tmrv_pkg::BATT_W-1:0] avg_o,
  output logic [1:0]                  repair_idx_o,
  output logic                        all_differ_o
);
  import tmrv_pkg::*;

  logic [BATT_W-1:0] d01, d02, d12;
  logic [BATT_W-1:0] pa, pb;
  logic [BATT_W:0]   pair_sum;

  // Pairwise distances
  assign d01 = (b0_i > b1_i) ? (b0_i - b1_i) : (b1_i - b0_i);
  assign d02 = (b0_i > b2_i) ? (b0_i - b2_i) : (b2_i - b0_i);
  assign d12 = (b1_i > b2_i) ? (b1_i - b2_i) : (b2_i - b1_i);

  // Choose the closest pair; ties favor the lower pair
  always_comb begin
    if (d01 <= d02 && d01 <= d12) begin
      pa = b0_i; pb = b1_i; repair_idx_o = 2'd2;
    end else if (d02 <= d01 && d02 <= d12) begin
      pa = b0_i; pb = b2_i; repair_idx_o = 2'd1;
    end else begin
      pa = b1_i; pb = b2_i; repair_idx_o = 2'd0;
    end
  end

  // Average rounded down
  assign pair_sum = {1'b0, pa} + {1'b0, pb};
  assign avg_o    = pair_sum[BATT_W:1];

  assign all_differ_o = (b0_i != b1_i) && (b0_i != b2_i) && (b1_i != b2_i);

endmodule

[hw/rtl/tmr_voted_register_file_top.sv]
// ----------------------------------------------------------------------------
// tmr_voted_register_file_top
// Triple-redundant register file with voted reads, scrub and fault inject.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on start_i/req_i and are taken at any clock edge with
//   start_i high and busy_o low. busy_o stays low, so one command can be
//   issued every cycle. Each command gives exactly one result transaction on
//   rsp_o, marked by rsp_valid_o for a single cycle, once the command has passed
//   the input register and then the result register. The
//   receiver cannot stall; results must be sampled when rsp_valid_o is high.
//   Commands apply in order: each one sees the copies as left by the one
//   before, since the voting and repair fit between the two registers.
//   The user must write the safe mode code through cfg_we_i/cfg_wdata_i only
//   while no command is in flight; the block itself does not enforce this.
//   Reset (rst_ni low, asynchronous) clears the pipeline valid bits, sets the
//   mode, timestamp and sequence copies and the correction count to zero,
//   the battery copies to fifty percent and the safe code to one.
// ----------------------------------------------------------------------------
module tmr_voted_register_file_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  tmrv_pkg::tmrv_req_t           req_i,
  output logic                          rsp_valid_o,
  output tmrv_pkg::tmrv_rsp_t           rsp_o,
  input  logic                          cfg_we_i,
  input  logic [tmrv_pkg::MODE_W-1:0]   cfg_wdata_i
);
  import tmrv_pkg::*;

  // Input register
  logic      req_valid_q;
  tmrv_req_t req_q;

  // Result register
  logic      rsp_valid_q;
  tmrv_rsp_t rsp_q, rsp_d;

  // Safe mode code
  logic [MODE_W-1:0] safe_code_q;

  // Redundant copies and scrub counter
  logic [MODE_W-1:0]  mode_q [NUM_COPIES];
  logic [MODE_W-1:0]  mode_d [NUM_COPIES];
  logic [BATT_W-1:0]  batt_q [NUM_COPIES];
  logic [BATT_W-1:0]  batt_d [NUM_COPIES];
  logic [TIME_W-1:0]  time_q [NUM_COPIES];
  logic [TIME_W-1:0]  time_d [NUM_COPIES];
  logic [SEQ_W-1:0]   seq_q  [NUM_COPIES];
  logic [SEQ_W-1:0]   seq_d  [NUM_COPIES];
  logic [COUNT_W-1:0] count_q, count_d;

  // Voter results
  logic [MODE_W-1:0]  mode_win;
  logic [TIME_W-1:0]  time_win;
  logic [SEQ_W-1:0]   seq_win;
  logic [BATT_W-1:0]  batt_avg;
  logic [1:0]         batt_idx;
  logic               batt_differ;
  tmrv_vote_flags_t   mode_flags, time_flags, seq_flags;
  logic [BATT_W-1:0]  batt_wr;

  // Every command completes in one pass, so commands are always taken
  assign busy_o = 1'b0;

  // Vote the mode copies, safe code on total disagreement
  tmrv_vote #(.W(MODE_W)) u_vote_mode (
    .c0_i       (mode_q[0]),
    .c1_i       (mode_q[1]),
    .c2_i       (mode_q[2]),
    .use_max_i  (1'b0),
    .fallback_i (safe_code_q),
    .winner_o   (mode_win),
    .flags_o    (mode_flags)
  );

  // Vote the timestamp copies, largest on total disagreement
  tmrv_vote #(.W(TIME_W)) u_vote_time (
    .c0_i       (time_q[0]),
    .c1_i       (time_q[1]),
    .c2_i       (time_q[2]),
    .use_max_i  (1'b1),
    .fallback_i ('0),
    .winner_o   (time_win),
    .flags_o    (time_flags)
  );

  // Vote the sequence copies, largest on total disagreement
  tmrv_vote #(.W(SEQ_W)) u_vote_seq (
    .c0_i       (seq_q[0]),
    .c1_i       (seq_q[1]),
    .c2_i       (seq_q[2]),
    .use_max_i  (1'b1),
    .fallback_i ('0),
    .winner_o   (seq_win),
    .flags_o    (seq_flags)
  );

  // Average the closest battery pair
  tmrv_batt_vote u_vote_batt (
    .b0_i         (batt_q[0]),
    .b1_i         (batt_q[1]),
    .b2_i         (batt_q[2]),
    .avg_o        (batt_avg),
    .repair_idx_o (batt_idx),
    .all_differ_o (batt_differ)
  );

  // Saturate battery write data at full charge
  assign batt_wr = (req_q.value > DATA_W'(BATT_FULL_Q8)) ? BATT_FULL_Q8
                                                        : req_q.value[BATT_W-1:0];

  // Decode the command, update copies and form the result
  always_comb begin
    mode_d  = mode_q;
    batt_d  = batt_q;
    time_d  = time_q;
    seq_d   = seq_q;
    count_d = count_q;
    rsp_d   = '0;
    if (req_valid_q) begin
      unique case (req_q.opcode)
        OP_WR_MODE: begin
          mode_d = '{default: req_q.value[MODE_W-1:0]};
        end
        OP_WR_BATT: begin
          batt_d = '{default: batt_wr};
        end
        OP_WR_TIME: begin
          time_d = '{default: req_q.value[TIME_W-1:0]};
        end
        OP_WR_SEQ: begin
          seq_d = '{default: req_q.value[SEQ_W-1:0]};
        end
        OP_RD_MODE: begin
          rsp_d.no_majority = mode_flags.all_differ;
          rsp_d.read_value  = DATA_W'(mode_win);
          mode_d            = '{default: mode_win};
        end
        OP_RD_BATT: begin
          rsp_d.no_majority = batt_differ;
          rsp_d.read_value  = DATA_W'(batt_avg);
          batt_d[batt_idx]  = batt_avg;
        end
        OP_RD_TIME: begin
          rsp_d.no_majority = time_flags.all_differ;
          rsp_d.read_value  = DATA_W'(time_win);
          time_d            = '{default: time_win};
        end
        OP_RD_SEQ: begin
          rsp_d.no_majority = seq_flags.all_differ;
          rsp_d.read_value  = DATA_W'(seq_win);
          seq_d             = '{default: seq_win};
        end
        OP_SCRUB: begin
          rsp_d.corrected  = !mode_flags.all_equal || !time_flags.all_equal;
          mode_d           = '{default: mode_win};
          time_d           = '{default: time_win};
          batt_d[batt_idx] = batt_avg;
          seq_d            = '{default: seq_win};
          if (rsp_d.corrected) begin
            count_d = count_q + 1'b1;
          end
        end
        OP_INJECT: begin
          // Drop injects aimed at a copy that does not exist
          if (32'(req_q.copy_index) < NUM_COPIES) begin
            unique case (req_q.field_select)
              FLD_MODE: mode_d[req_q.copy_index] = req_q.value[MODE_W-1:0];
              FLD_BATT: batt_d[req_q.copy_index] = req_q.value[BATT_W-1:0];
              FLD_TIME: time_d[req_q.copy_index] = req_q.value[TIME_W-1:0];
              default:  seq_d[req_q.copy_index]  = req_q.value[SEQ_W-1:0];
            endcase
          end
        end
        default: begin
        end
      endcase
    end
    rsp_d.correction_count = count_d;
  end

  // Hold copies, counter, safe code and pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      rsp_valid_q <= 1'b0;
      safe_code_q <= SAFE_CODE_RESET;
      mode_q      <= '{default: '0};
      batt_q      <= '{default: BATT_RESET_Q8};
      time_q      <= '{default: '0};
      seq_q       <= '{default: '0};
      count_q     <= '0;
    end else begin
      req_valid_q <= start_i && !busy_o;
      rsp_valid_q <= req_valid_q;
      if (cfg_we_i) begin
        safe_code_q <= cfg_wdata_i;
      end
      mode_q  <= mode_d;
      batt_q  <= batt_d;
      time_q  <= time_d;
      seq_q   <= seq_d;
      count_q <= count_d;
    end
  end

  // Capture the incoming transaction and the result payload
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      req_q <= req_i;
    end
    if (req_valid_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

[hw/rtl/tmrv_checker.sv]
// ----------------------------------------------------------------------------
// tmrv_checker
// Port-level checks of the voted register file, bound to the top level.
// ----------------------------------------------------------------------------
module tmrv_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start_i,
  input logic                        busy_o,
  input tmrv_pkg::tmrv_req_t         req_i,
  input logic                        rsp_valid_o,
  input tmrv_pkg::tmrv_rsp_t         rsp_o
);
  import tmrv_pkg::*;

  // Every accepted transaction yields a result after the input and result registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> ##1 rsp_valid_o)
    else $error("tmrv: result missing after accepted transaction");

  // No result without a matching accepted transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> $past(start_i && !busy_o, 2))
    else $error("tmrv: result without transaction");

  // Only reads return data or flag a missing majority
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && ($past(req_i.opcode, 2) < OP_RD_MODE ||
                     $past(req_i.opcode, 2) > OP_RD_SEQ))
    |-> (rsp_o.read_value == '0 && !rsp_o.no_majority))
    else $error("tmrv: non-read returned data");

  // Back-to-back results: count steps by one exactly when corrected is set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && $past(rsp_valid_o)) |->
      (rsp_o.correction_count ==
       $past(rsp_o.correction_count) + COUNT_W'(rsp_o.corrected)))
    else $error("tmrv: correction count out of step");

endmodule

bind tmr_voted_register_file_top tmrv_checker u_tmrv_checker (.*);

[tb/tmr_voted_register_file_checker.sv]
// ----------------------------------------------------------------------------
// tmr_voted_register_file_checker
// Predicts and checks every result transaction of the voted register file.
// Keeps its own three copies of each field and the safe mode code, updates
// them on each accepted command and config write, and compares each result
// field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module tmr_voted_register_file_checker
  import tmrv_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  tmrv_req_t           req_i,
  input  logic                rsp_valid_i,
  input  tmrv_rsp_t           rsp_i,
  input  logic                cfg_we_i,
  input  logic [MODE_W-1:0]   cfg_wdata_i,
  output int unsigned         mismatch_count_o,
  output int unsigned         outstanding_o
);

  // Shadow copies of the redundant fields
  logic [MODE_W-1:0]  mode_cp [NUM_COPIES];
  logic [BATT_W-1:0]  batt_cp [NUM_COPIES];
  logic [TIME_W-1:0]  time_cp [NUM_COPIES];
  logic [SEQ_W-1:0]   seq_cp  [NUM_COPIES];
  logic [COUNT_W-1:0] fix_count;
  logic [MODE_W-1:0]  safe_code;

  tmrv_rsp_t expected_rsp_q [$];

  function automatic logic all_distinct(input logic [31:0] a, b, c);
    return (a != b) && (a != c) && (b != c);
  endfunction

  // Two-of-three winner; with no majority take the largest or the fallback
  function automatic logic [31:0] majority_of(input logic [31:0] a, b, c,
                                              input logic take_max,
                                              input logic [31:0] fallback);
    logic [31:0] win;
    if (a == b) begin
      win = a;
    end else if (a == c) begin
      win = a;
    end else if (b == c) begin
      win = b;
    end else if (take_max) begin
      win = a;
      if (b > win) win = b;
      if (c > win) win = c;
    end else begin
      win = fallback;
    end
    return win;
  endfunction

  // Every vote except battery leaves all three copies equal to the winner
  task automatic vote_mode(output logic [31:0] win);
    win = majority_of(32'(mode_cp[0]), 32'(mode_cp[1]), 32'(mode_cp[2]),
                      1'b0, 32'(safe_code));
    for (int k = 0; k < NUM_COPIES; k++) mode_cp[k] = win[MODE_W-1:0];
  endtask

  task automatic vote_time(output logic [31:0] win);
    win = majority_of(time_cp[0], time_cp[1], time_cp[2], 1'b1, '0);
    for (int k = 0; k < NUM_COPIES; k++) time_cp[k] = win;
  endtask

  task automatic vote_seq(output logic [31:0] win);
    win = majority_of(32'(seq_cp[0]), 32'(seq_cp[1]), 32'(seq_cp[2]), 1'b1, '0);
    for (int k = 0; k < NUM_COPIES; k++) seq_cp[k] = win[SEQ_W-1:0];
  endtask

  // Average the closest pair (earlier pair wins ties), overwrite the third
  task automatic vote_batt(output logic [31:0] win);
    logic [BATT_W-1:0] d01, d02, d12;
    logic [BATT_W:0]   pair_sum;
    d01 = (batt_cp[0] > batt_cp[1]) ? batt_cp[0] - batt_cp[1] : batt_cp[1] - batt_cp[0];
    d02 = (batt_cp[0] > batt_cp[2]) ? batt_cp[0] - batt_cp[2] : batt_cp[2] - batt_cp[0];
    d12 = (batt_cp[1] > batt_cp[2]) ? batt_cp[1] - batt_cp[2] : batt_cp[2] - batt_cp[1];
    if (d01 <= d02 && d01 <= d12) begin
      pair_sum = {1'b0, batt_cp[0]} + {1'b0, batt_cp[1]};
      batt_cp[2] = pair_sum[BATT_W:1];
    end else if (d02 <= d01 && d02 <= d12) begin
      pair_sum = {1'b0, batt_cp[0]} + {1'b0, batt_cp[2]};
      batt_cp[1] = pair_sum[BATT_W:1];
    end else begin
      pair_sum = {1'b0, batt_cp[1]} + {1'b0, batt_cp[2]};
      batt_cp[0] = pair_sum[BATT_W:1];
    end
    win = 32'(pair_sum[BATT_W:1]);
  endtask

  // Apply one command to the shadow copies and form its result
  task automatic predict_command(input tmrv_req_t cmd, output tmrv_rsp_t rsp);
    logic [31:0] win;
    logic        fix;
    rsp = '0;
    case (cmd.opcode)
      OP_WR_MODE: begin
        for (int k = 0; k < NUM_COPIES; k++) mode_cp[k] = cmd.value[MODE_W-1:0];
      end
      OP_WR_BATT: begin
        win = (cmd.value > 32'(BATT_FULL_Q8)) ? 32'(BATT_FULL_Q8) : cmd.value;
        for (int k = 0; k < NUM_COPIES; k++) batt_cp[k] = win[BATT_W-1:0];
      end
      OP_WR_TIME: begin
        for (int k = 0; k < NUM_COPIES; k++) time_cp[k] = cmd.value;
      end
      OP_WR_SEQ: begin
        for (int k = 0; k < NUM_COPIES; k++) seq_cp[k] = cmd.value[SEQ_W-1:0];
      end
      OP_RD_MODE: begin
        rsp.no_majority = all_distinct(32'(mode_cp[0]), 32'(mode_cp[1]), 32'(mode_cp[2]));
        vote_mode(win);
        rsp.read_value = win;
      end
      OP_RD_BATT: begin
        rsp.no_majority = all_distinct(32'(batt_cp[0]), 32'(batt_cp[1]), 32'(batt_cp[2]));
        vote_batt(win);
        rsp.read_value = win;
      end
      OP_RD_TIME: begin
        rsp.no_majority = all_distinct(time_cp[0], time_cp[1], time_cp[2]);
        vote_time(win);
        rsp.read_value = win;
      end
      OP_RD_SEQ: begin
        rsp.no_majority = all_distinct(32'(seq_cp[0]), 32'(seq_cp[1]), 32'(seq_cp[2]));
        vote_seq(win);
        rsp.read_value = win;
      end
      OP_SCRUB: begin
        fix = !(mode_cp[0] == mode_cp[1] && mode_cp[1] == mode_cp[2]) ||
              !(time_cp[0] == time_cp[1] && time_cp[1] == time_cp[2]);
        vote_mode(win);
        vote_time(win);
        vote_batt(win);
        vote_seq(win);
        if (fix) fix_count = fix_count + 1'b1;
        rsp.corrected = fix;
      end
      OP_INJECT: begin
        if (cmd.copy_index < 2'(NUM_COPIES)) begin
          case (cmd.field_select)
            FLD_MODE: mode_cp[cmd.copy_index] = cmd.value[MODE_W-1:0];
            FLD_BATT: batt_cp[cmd.copy_index] = cmd.value[BATT_W-1:0];
            FLD_TIME: time_cp[cmd.copy_index] = cmd.value;
            default:  seq_cp[cmd.copy_index]  = cmd.value[SEQ_W-1:0];
          endcase
        end
      end
      default: ;
    endcase
    rsp.correction_count = fix_count;
  endtask

  // Check results, track config writes, predict accepted commands
  always @(posedge clk_i or negedge rst_ni) begin
    tmrv_rsp_t exp_rsp;
    tmrv_rsp_t new_rsp;
    if (!rst_ni) begin
      for (int k = 0; k < NUM_COPIES; k++) begin
        mode_cp[k] = '0;
        batt_cp[k] = BATT_RESET_Q8;
        time_cp[k] = '0;
        seq_cp[k]  = '0;
      end
      fix_count = '0;
      safe_code = SAFE_CODE_RESET;
      expected_rsp_q.delete();
      mismatch_count_o = 0;
    end else begin
      // Compare the result transaction of this cycle with the oldest one
      if (rsp_valid_i) begin
        if (expected_rsp_q.size() == 0) begin
          $error("unexpected result transaction: %p", rsp_i);
          mismatch_count_o++;
        end else begin
          exp_rsp = expected_rsp_q.pop_front();
          if (rsp_i.read_value !== exp_rsp.read_value) begin
            $error("read_value: expected %h, got %h", exp_rsp.read_value, rsp_i.read_value);
            mismatch_count_o++;
          end
          if (rsp_i.no_majority !== exp_rsp.no_majority) begin
            $error("no_majority: expected %b, got %b", exp_rsp.no_majority,
                   rsp_i.no_majority);
            mismatch_count_o++;
          end
          if (rsp_i.corrected !== exp_rsp.corrected) begin
            $error("corrected: expected %b, got %b", exp_rsp.corrected, rsp_i.corrected);
            mismatch_count_o++;
          end
          if (rsp_i.correction_count !== exp_rsp.correction_count) begin
            $error("correction_count: expected %h, got %h", exp_rsp.correction_count,
                   rsp_i.correction_count);
            mismatch_count_o++;
          end
        end
      end
      if (cfg_we_i) safe_code = cfg_wdata_i;
      // Predict the command transaction taken at this edge
      if (start_i && !busy_i) begin
        predict_command(req_i, new_rsp);
        expected_rsp_q.push_back(new_rsp);
      end
    end
    outstanding_o = expected_rsp_q.size();
  end

endmodule

[tb/tb_tmr_voted_register_file_top.sv]
// ----------------------------------------------------------------------------
// tb_tmr_voted_register_file_top
// Stimulus and verdict for the triple-redundant voted register file.
// Runs a directed sequence over field extremes, voting corner cases and
// injected faults, then random command phases under several safe mode codes
// with random gaps between commands. A checker beside the block predicts and
// compares every result transaction.
// ----------------------------------------------------------------------------
module tb_tmr_voted_register_file_top;
  import tmrv_pkg::*;

  localparam logic [3:0] OP_RESERVED_LO = 4'd10;
  localparam logic [3:0] OP_RESERVED_HI = 4'd15;
  localparam int         PIPE_DEPTH     = 2;
  localparam int         NUM_PHASES     = 5;
  localparam int         PHASE_ITEMS    = 185;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  tmrv_req_t         req_i;
  logic              rsp_valid_o;
  tmrv_rsp_t         rsp_o;
  logic              cfg_we_i;
  logic [MODE_W-1:0] cfg_wdata_i;
  int unsigned       mismatch_count;
  int unsigned       outstanding;
  int                quiet_left;

  tmr_voted_register_file_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  tmr_voted_register_file_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_i           (busy_o),
    .req_i            (req_i),
    .rsp_valid_i      (rsp_valid_o),
    .rsp_i            (rsp_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Drive one command transaction after a random gap; hold until taken
  task automatic issue(input logic [3:0] op, input logic [1:0] fsel,
                       input logic [1:0] cidx, input logic [31:0] val);
    int        gap;
    tmrv_req_t cmd;
    if (quiet_left > 0) begin
      gap = 0;
      quiet_left--;
    end else begin
      gap = $urandom_range(0, 8);
      if ($urandom_range(0, 19) == 0) quiet_left = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd.opcode       = op;
    cmd.field_select = fsel;
    cmd.copy_index   = cidx;
    cmd.value        = val;
    start_i <= 1'b1;
    req_i   <= cmd;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Stop issuing and wait until every result has come back
  task automatic drain();
    start_i <= 1'b0;
    repeat (PIPE_DEPTH + 1) @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic write_safe_code(input logic [MODE_W-1:0] code);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= code;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Favor small values so copies collide and battery pairs tie
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 4))
      0:       return 32'($urandom_range(0, 7));
      1:       return $urandom;
      2:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      3:       return 32'($urandom_range(25597, 25603));
      default: return 32'($urandom_range(32'h7FF8, 32'h8007));
    endcase
  endfunction

  task automatic random_command();
    int          pick;
    logic [3:0]  op;
    pick = $urandom_range(0, 99);
    if (pick < 30)      op = OP_INJECT;
    else if (pick < 55) op = 4'($urandom_range(OP_RD_MODE, OP_RD_SEQ));
    else if (pick < 75) op = 4'($urandom_range(OP_WR_MODE, OP_WR_SEQ));
    else if (pick < 90) op = OP_SCRUB;
    else if (pick < 95) op = 4'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));
    else                op = 4'($urandom_range(OP_RD_MODE, OP_RD_SEQ));
    issue(op, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), pick_value());
  endtask

  initial begin
    logic [MODE_W-1:0] phase_code;
    quiet_left  = 0;
    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    req_i       <= '0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Read the reset values
    issue(OP_RD_MODE, FLD_MODE, 2'd0, 32'h0);
    issue(OP_RD_BATT, FLD_BATT, 2'd1, 32'h0);
    issue(OP_RD_TIME, FLD_TIME, 2'd2, 32'h0);
    issue(OP_RD_SEQ,  FLD_SEQ,  2'd3, 32'h0);
    // Wide write data; battery saturates
    issue(OP_WR_MODE, FLD_SEQ, 2'd3, 32'hFFFF_FFFF);
    issue(OP_WR_BATT, FLD_SEQ, 2'd3, 32'hFFFF_FFFF);
    issue(OP_WR_TIME, FLD_SEQ, 2'd3, 32'hFFFF_FFFF);
    issue(OP_WR_SEQ,  FLD_SEQ, 2'd3, 32'hFFFF_ABCD);
    // Mode copies all differ: fall back to the safe code
    issue(OP_INJECT,  FLD_MODE, 2'd0, 32'h3);
    issue(OP_INJECT,  FLD_MODE, 2'd1, 32'h5);
    issue(OP_RD_MODE, FLD_MODE, 2'd0, 32'h0);
    // Battery pair distances tie: first pair wins
    issue(OP_INJECT,  FLD_BATT, 2'd0, 32'd100);
    issue(OP_INJECT,  FLD_BATT, 2'd1, 32'd50);
    issue(OP_INJECT,  FLD_BATT, 2'd2, 32'd150);
    issue(OP_RD_BATT, FLD_BATT, 2'd0, 32'h0);
    // Timestamp copies all differ, then scrub takes the largest
    issue(OP_INJECT,  FLD_TIME, 2'd0, 32'h0);
    issue(OP_INJECT,  FLD_TIME, 2'd1, 32'h1234_5678);
    issue(OP_INJECT,  FLD_SEQ,  2'd3, 32'h0000_0000);
    issue(OP_SCRUB,   FLD_MODE, 2'd0, 32'h0);
    issue(OP_RD_TIME, FLD_TIME, 2'd0, 32'h0);
    issue(OP_SCRUB,   FLD_MODE, 2'd0, 32'h0);
    issue(OP_RESERVED_HI, FLD_SEQ, 2'd3, 32'hFFFF_FFFF);
    // Saturation boundary and a raw battery inject
    issue(OP_WR_BATT, FLD_BATT, 2'd0, 32'd25600);
    issue(OP_WR_BATT, FLD_BATT, 2'd0, 32'd25601);
    issue(OP_INJECT,  FLD_BATT, 2'd2, 32'hFFFF_FFFF);
    issue(OP_RD_BATT, FLD_BATT, 2'd0, 32'h0);
    drain();

    // Random phases under several safe codes: the reset code, then the extremes, then random ones
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase > 0) begin
        case (phase)
          1:       phase_code = '1;
          2:       phase_code = '0;
          default: phase_code = MODE_W'($urandom_range(0, 15));
        endcase
        write_safe_code(phase_code);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) random_command();
      drain();
    end

    repeat (PIPE_DEPTH + 2) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin
    #200000;
    $display("Mismatches found");
    $finish;
  end

endmodule

[files.f]
hw/rtl/tmrv_pkg.sv
hw/rtl/tmrv_vote.sv
hw/rtl/tmrv_batt_vote.sv
hw/rtl/tmr_voted_register_file_top.sv
hw/rtl/tmrv_checker.sv
tb/tmr_voted_register_file_checker.sv
tb/tb_tmr_voted_register_file_top.sv
